// ----- hdl/line_pixel_generator_defines.svh -----
// assertion helpers used by the checker file
`ifndef LINE_PIXEL_GENERATOR_DEFINES_SVH
`define LINE_PIXEL_GENERATOR_DEFINES_SVH

// antecedent and consequent in the same cycle
`define LPG_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("line pixel generator check failed");

// consequent in the cycle after the antecedent
`define LPG_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("line pixel generator check failed");

`endif

// ----- hdl/lpg_pkg.sv -----
package lpg_pkg;

  // field widths
  localparam int COORD_BITS = 13;
  localparam int FRAME_MAX  = 4096;
  localparam int REG_BITS   = 13;
  localparam int COLOR_BITS = 24;
  localparam int ADDR_BITS  = 26;

  // derived widths
  localparam int SPAN_BITS  = COORD_BITS + 1;
  localparam int ERR_BITS   = COORD_BITS + 3;
  localparam int TWICE_BITS = ERR_BITS + 1;
  localparam int FRAME_BITS = $clog2(FRAME_MAX + 1);
  localparam int PROD_BITS  = (COORD_BITS - 1) + FRAME_BITS;
  localparam int MATH_BITS  = (PROD_BITS + 3 > ADDR_BITS) ? PROD_BITS + 3 : ADDR_BITS;

  // stream packing
  localparam int IN_FIELD_BITS  = 4 * COORD_BITS + COLOR_BITS;
  localparam int IN_DATA_BITS   = ((IN_FIELD_BITS + 7) / 8) * 8;
  localparam int OUT_FIELD_BITS = 2 * COORD_BITS + ADDR_BITS + COLOR_BITS;
  localparam int OUT_DATA_BITS  = ((OUT_FIELD_BITS + 7) / 8) * 8;

  // pixel queue
  localparam int QDEPTH    = 4;
  localparam int QPTR_BITS = $clog2(QDEPTH);

  // configuration
  localparam int CFG_IDX_BITS = 1;
  localparam logic [CFG_IDX_BITS-1:0] REG_FRAME_WIDTH  = 1'd0;
  localparam logic [CFG_IDX_BITS-1:0] REG_FRAME_HEIGHT = 1'd1;
  localparam logic [REG_BITS-1:0] FRAME_WIDTH_RESET  = REG_BITS'(640);
  localparam logic [REG_BITS-1:0] FRAME_HEIGHT_RESET = REG_BITS'(480);

  // operation codes
  localparam logic OP_START = 1'b0;
  localparam logic OP_STEP  = 1'b1;

  typedef struct packed {
    logic                         op;
    logic signed [COORD_BITS-1:0] start_x;
    logic signed [COORD_BITS-1:0] start_y;
    logic signed [COORD_BITS-1:0] end_x;
    logic signed [COORD_BITS-1:0] end_y;
    logic [COLOR_BITS-1:0]        color;
  } in_item_t;

  typedef struct packed {
    logic signed [COORD_BITS-1:0] x;
    logic signed [COORD_BITS-1:0] y;
    logic [COLOR_BITS-1:0]        color;
    logic                         last;
  } pix_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

endpackage

// ----- hdl/lpg_front.sv -----
module lpg_front (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_tvalid,
  output logic               in_tready,
  input  lpg_pkg::in_item_t  in_item,
  input  lpg_pkg::q_stat_t   q_stat,
  output logic               push,
  output lpg_pkg::pix_t      push_pix
);

  logic signed [lpg_pkg::COORD_BITS-1:0] cur_x_r, cur_x_nxt, cur_y_r, cur_y_nxt;
  logic signed [lpg_pkg::COORD_BITS-1:0] tgt_x_r, tgt_x_nxt, tgt_y_r, tgt_y_nxt;
  logic [lpg_pkg::SPAN_BITS-1:0]         span_x_r, span_x_nxt, span_y_r, span_y_nxt;
  logic                                  dir_x_neg_r, dir_x_neg_nxt;
  logic                                  dir_y_neg_r, dir_y_neg_nxt;
  logic signed [lpg_pkg::ERR_BITS-1:0]   err_r, err_nxt;
  logic [lpg_pkg::COLOR_BITS-1:0]        color_r, color_nxt;
  logic                                  busy_r, busy_nxt;

  logic signed [lpg_pkg::COORD_BITS-1:0] x1, y1, x2, y2;
  logic signed [lpg_pkg::SPAN_BITS-1:0]  dx, dy;
  logic [lpg_pkg::SPAN_BITS-1:0]         span_x_c, span_y_c;
  logic                                  busy_start;
  logic signed [lpg_pkg::TWICE_BITS-1:0] twice, sx_e, sy_e, err_ext, err_sum;
  logic                                  step_x, step_y;
  logic signed [lpg_pkg::COORD_BITS-1:0] cur_x_step, cur_y_step;
  logic                                  busy_step;
  logic                                  in_fire, is_start;

  assign in_tready = !q_stat.full;
  assign in_fire   = in_tvalid && in_tready;
  assign is_start  = (in_item.op == lpg_pkg::OP_START);

  // start decode: spans and directions
  assign x1 = in_item.start_x;
  assign y1 = in_item.start_y;
  assign x2 = in_item.end_x;
  assign y2 = in_item.end_y;
  assign dx = $signed({x2[lpg_pkg::COORD_BITS-1], x2}) - $signed({x1[lpg_pkg::COORD_BITS-1], x1});
  assign dy = $signed({y2[lpg_pkg::COORD_BITS-1], y2}) - $signed({y1[lpg_pkg::COORD_BITS-1], y1});
  assign span_x_c   = dx[lpg_pkg::SPAN_BITS-1] ? (~dx + 1'b1) : dx;
  assign span_y_c   = dy[lpg_pkg::SPAN_BITS-1] ? (~dy + 1'b1) : dy;
  assign busy_start = (x1 != x2) || (y1 != y2);

  // error-term step
  assign twice   = $signed({err_r, 1'b0});
  assign sx_e    = $signed(lpg_pkg::TWICE_BITS'(span_x_r));
  assign sy_e    = $signed(lpg_pkg::TWICE_BITS'(span_y_r));
  assign err_ext = $signed({err_r[lpg_pkg::ERR_BITS-1], err_r});
  assign step_x  = (twice > -sy_e);
  assign step_y  = (twice < sx_e);
  assign err_sum = err_ext - (step_x ? sy_e : '0) + (step_y ? sx_e : '0);

  assign cur_x_step = step_x ? (dir_x_neg_r ? cur_x_r - 1'b1 : cur_x_r + 1'b1) : cur_x_r;
  assign cur_y_step = step_y ? (dir_y_neg_r ? cur_y_r - 1'b1 : cur_y_r + 1'b1) : cur_y_r;
  assign busy_step  = (cur_x_step != tgt_x_r) || (cur_y_step != tgt_y_r);

  // pixel record toward the queue
  assign push = in_fire && (is_start || busy_r);
  always_comb begin
    if (is_start) begin
      push_pix = '{x: x2, y: y2, color: in_item.color, last: !busy_start};
    end else begin
      push_pix = '{x: cur_x_r, y: cur_y_r, color: color_r, last: !busy_step};
    end
  end

  // line state next values
  always_comb begin
    cur_x_nxt     = cur_x_r;
    cur_y_nxt     = cur_y_r;
    tgt_x_nxt     = tgt_x_r;
    tgt_y_nxt     = tgt_y_r;
    span_x_nxt    = span_x_r;
    span_y_nxt    = span_y_r;
    dir_x_neg_nxt = dir_x_neg_r;
    dir_y_neg_nxt = dir_y_neg_r;
    err_nxt       = err_r;
    color_nxt     = color_r;
    busy_nxt      = busy_r;
    if (in_fire && is_start) begin
      cur_x_nxt     = x1;
      cur_y_nxt     = y1;
      tgt_x_nxt     = x2;
      tgt_y_nxt     = y2;
      span_x_nxt    = span_x_c;
      span_y_nxt    = span_y_c;
      dir_x_neg_nxt = !(x1 < x2);
      dir_y_neg_nxt = !(y1 < y2);
      err_nxt       = $signed(lpg_pkg::ERR_BITS'(span_x_c) - lpg_pkg::ERR_BITS'(span_y_c));
      color_nxt     = in_item.color;
      busy_nxt      = busy_start;
    end else if (in_fire && busy_r) begin
      cur_x_nxt = cur_x_step;
      cur_y_nxt = cur_y_step;
      err_nxt   = err_sum[lpg_pkg::ERR_BITS-1:0];
      busy_nxt  = busy_step;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_x_r     <= '0;
      cur_y_r     <= '0;
      tgt_x_r     <= '0;
      tgt_y_r     <= '0;
      span_x_r    <= '0;
      span_y_r    <= '0;
      dir_x_neg_r <= 1'b0;
      dir_y_neg_r <= 1'b0;
      err_r       <= '0;
      color_r     <= '0;
      busy_r      <= 1'b0;
    end else begin
      cur_x_r     <= cur_x_nxt;
      cur_y_r     <= cur_y_nxt;
      tgt_x_r     <= tgt_x_nxt;
      tgt_y_r     <= tgt_y_nxt;
      span_x_r    <= span_x_nxt;
      span_y_r    <= span_y_nxt;
      dir_x_neg_r <= dir_x_neg_nxt;
      dir_y_neg_r <= dir_y_neg_nxt;
      err_r       <= err_nxt;
      color_r     <= color_nxt;
      busy_r      <= busy_nxt;
    end
  end

endmodule

// ----- hdl/lpg_queue.sv -----
module lpg_queue (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  lpg_pkg::pix_t    push_pix,
  input  logic             pop,
  output lpg_pkg::pix_t    head_pix,
  output lpg_pkg::q_stat_t q_stat
);

  lpg_pkg::pix_t                 mem_r [lpg_pkg::QDEPTH];
  logic [lpg_pkg::QPTR_BITS-1:0] wr_ptr_r, wr_ptr_nxt, rd_ptr_r, rd_ptr_nxt;
  logic [lpg_pkg::QPTR_BITS:0]   cnt_r, cnt_nxt;
  logic                          do_push, do_pop;

  assign q_stat.full  = (cnt_r == (lpg_pkg::QPTR_BITS + 1)'(lpg_pkg::QDEPTH));
  assign q_stat.empty = (cnt_r == '0);
  assign do_push      = push && !q_stat.full;
  assign do_pop       = pop && !q_stat.empty;
  assign head_pix     = mem_r[rd_ptr_r];

  // pointers and fill count
  always_comb begin
    wr_ptr_nxt = do_push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = do_pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    cnt_nxt    = cnt_r + {{lpg_pkg::QPTR_BITS{1'b0}}, do_push}
                       - {{lpg_pkg::QPTR_BITS{1'b0}}, do_pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // entry storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_pix;
    end
  end

endmodule

// ----- hdl/lpg_back.sv -----
module lpg_back (
  input  logic                                clk,
  input  logic                                rst_n,
  input  lpg_pkg::pix_t                       head_pix,
  input  lpg_pkg::q_stat_t                    q_stat,
  output logic                                pop,
  input  logic [lpg_pkg::REG_BITS-1:0]        frame_w,
  input  logic [lpg_pkg::REG_BITS-1:0]        frame_h,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic signed [lpg_pkg::COORD_BITS-1:0] out_x,
  output logic signed [lpg_pkg::COORD_BITS-1:0] out_y,
  output logic [lpg_pkg::ADDR_BITS-1:0]       out_addr,
  output logic [lpg_pkg::COLOR_BITS-1:0]      out_color,
  output logic                                out_off,
  output logic                                out_last
);

  logic [lpg_pkg::FRAME_BITS-1:0]   w_eff, h_eff;
  logic [lpg_pkg::COORD_BITS-2:0]   hx_u, hy_u;
  logic                             off_c;
  logic [lpg_pkg::PROD_BITS-1:0]    prod_c;
  logic                             adv;

  logic                             s1_valid_r, s1_valid_nxt;
  lpg_pkg::pix_t                    s1_pix_r;
  logic                             s1_off_r;
  logic [lpg_pkg::PROD_BITS-1:0]    s1_prod_r;

  logic [lpg_pkg::MATH_BITS-1:0]    sum_c, addr_m;
  logic                             out_valid_r, out_valid_nxt;
  logic signed [lpg_pkg::COORD_BITS-1:0] out_x_r, out_y_r;
  logic [lpg_pkg::ADDR_BITS-1:0]    out_addr_r;
  logic [lpg_pkg::COLOR_BITS-1:0]   out_color_r;
  logic                             out_off_r, out_last_r;

  // frame size clamped to the buffer limit
  assign w_eff = (32'(frame_w) > lpg_pkg::FRAME_MAX) ? lpg_pkg::FRAME_BITS'(lpg_pkg::FRAME_MAX)
                                                     : lpg_pkg::FRAME_BITS'(frame_w);
  assign h_eff = (32'(frame_h) > lpg_pkg::FRAME_MAX) ? lpg_pkg::FRAME_BITS'(lpg_pkg::FRAME_MAX)
                                                     : lpg_pkg::FRAME_BITS'(frame_h);

  // whole pipeline moves unless the output beat is stalled
  assign adv = !out_valid_r || out_ready;
  assign pop = adv && !q_stat.empty;

  // stage one: bounds check and row offset
  assign hx_u  = head_pix.x[lpg_pkg::COORD_BITS-2:0];
  assign hy_u  = head_pix.y[lpg_pkg::COORD_BITS-2:0];
  assign off_c = head_pix.x[lpg_pkg::COORD_BITS-1] || head_pix.y[lpg_pkg::COORD_BITS-1] ||
                 (32'(hx_u) >= 32'(w_eff)) || (32'(hy_u) >= 32'(h_eff));
  assign prod_c = hy_u * w_eff;

  assign s1_valid_nxt = adv ? !q_stat.empty : s1_valid_r;

  // stage two: add column and scale by three bytes
  assign sum_c  = lpg_pkg::MATH_BITS'(s1_prod_r)
                + lpg_pkg::MATH_BITS'(s1_pix_r.x[lpg_pkg::COORD_BITS-2:0]);
  assign addr_m = sum_c + (sum_c << 1);

  assign out_valid_nxt = adv ? s1_valid_r : out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (adv) begin
      s1_pix_r    <= head_pix;
      s1_off_r    <= off_c;
      s1_prod_r   <= prod_c;
      out_x_r     <= s1_pix_r.x;
      out_y_r     <= s1_pix_r.y;
      out_addr_r  <= s1_off_r ? '0 : addr_m[lpg_pkg::ADDR_BITS-1:0];
      out_color_r <= s1_pix_r.color;
      out_off_r   <= s1_off_r;
      out_last_r  <= s1_pix_r.last;
    end
  end

  assign out_valid = out_valid_r;
  assign out_x     = out_x_r;
  assign out_y     = out_y_r;
  assign out_addr  = out_addr_r;
  assign out_color = out_color_r;
  assign out_off   = out_off_r;
  assign out_last  = out_last_r;

endmodule

// ----- hdl/line_pixel_generator.sv -----
// pixel path: an accepted pixel is written into the queue, then registered in stage one and in the output register
// throughput: one input beat per cycle while the queue is not full; start always yields a pixel, step yields one
// only while a line is active; set by the combinational error-term update in the front
// reset: synchronous active-low rst_n clears line state, queue and output valid, and
// returns frame_width to 640 and frame_height to 480
module line_pixel_generator (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_tvalid,
  output logic                                 in_tready,
  // start_x, start_y, end_x, end_y, line_color, zero pad
  input  logic [lpg_pkg::IN_DATA_BITS-1:0]     in_tdata,
  // operation
  input  logic                                 in_tuser,
  output logic                                 out_tvalid,
  input  logic                                 out_tready,
  // pixel_x, pixel_y, byte_address, pixel_color, zero pad
  output logic [lpg_pkg::OUT_DATA_BITS-1:0]    out_tdata,
  // off_screen
  output logic                                 out_tuser,
  output logic                                 out_tlast,
  input  logic                                 cfg_we,
  input  logic [lpg_pkg::CFG_IDX_BITS-1:0]     cfg_index,
  input  logic [lpg_pkg::REG_BITS-1:0]         cfg_data
);

  localparam int C = lpg_pkg::COORD_BITS;

  logic [lpg_pkg::REG_BITS-1:0] frame_w_r, frame_w_nxt, frame_h_r, frame_h_nxt;

  lpg_pkg::in_item_t in_item;
  lpg_pkg::pix_t     push_pix, head_pix;
  lpg_pkg::q_stat_t  q_stat;
  logic              push, pop;

  logic signed [C-1:0]             px, py;
  logic [lpg_pkg::ADDR_BITS-1:0]   paddr;
  logic [lpg_pkg::COLOR_BITS-1:0]  pcolor;

  // configuration registers
  always_comb begin
    frame_w_nxt = frame_w_r;
    frame_h_nxt = frame_h_r;
    if (cfg_we) begin
      case (cfg_index)
        lpg_pkg::REG_FRAME_WIDTH:  frame_w_nxt = cfg_data;
        lpg_pkg::REG_FRAME_HEIGHT: frame_h_nxt = cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_w_r <= lpg_pkg::FRAME_WIDTH_RESET;
      frame_h_r <= lpg_pkg::FRAME_HEIGHT_RESET;
    end else begin
      frame_w_r <= frame_w_nxt;
      frame_h_r <= frame_h_nxt;
    end
  end

  // input beat unpacking
  assign in_item.op      = in_tuser;
  assign in_item.start_x = in_tdata[0*C +: C];
  assign in_item.start_y = in_tdata[1*C +: C];
  assign in_item.end_x   = in_tdata[2*C +: C];
  assign in_item.end_y   = in_tdata[3*C +: C];
  assign in_item.color   = in_tdata[4*C +: lpg_pkg::COLOR_BITS];

  lpg_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_item   (in_item),
    .q_stat    (q_stat),
    .push      (push),
    .push_pix  (push_pix)
  );

  lpg_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_pix (push_pix),
    .pop      (pop),
    .head_pix (head_pix),
    .q_stat   (q_stat)
  );

  lpg_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .head_pix  (head_pix),
    .q_stat    (q_stat),
    .pop       (pop),
    .frame_w   (frame_w_r),
    .frame_h   (frame_h_r),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_x     (px),
    .out_y     (py),
    .out_addr  (paddr),
    .out_color (pcolor),
    .out_off   (out_tuser),
    .out_last  (out_tlast)
  );

  // output beat packing
  assign out_tdata = lpg_pkg::OUT_DATA_BITS'({pcolor, paddr, py, px});

endmodule

// ----- hdl/lpg_checker.sv -----
`include "line_pixel_generator_defines.svh"

module lpg_checker (
  input logic                              clk,
  input logic                              rst_n,
  input logic                              out_tvalid,
  input logic                              out_tready,
  input logic [lpg_pkg::OUT_DATA_BITS-1:0] out_tdata,
  input logic                              out_tuser,
  input logic                              out_tlast
);

  localparam int C      = lpg_pkg::COORD_BITS;
  localparam int ADDR_W = lpg_pkg::ADDR_BITS;
  localparam int X_MSB  = C - 1;
  localparam int Y_MSB  = 2 * C - 1;

  logic [lpg_pkg::OUT_DATA_BITS+1:0] out_beat;

  // whole result beat as seen on the ports
  assign out_beat = {out_tdata, out_tuser, out_tlast};

  // a suppressed write never carries an address
  `LPG_ASSERT_SAME(a_off_addr_zero, out_tvalid && out_tuser, out_tdata[2*C +: ADDR_W] == '0)

  // an on-screen pixel has non-negative coordinates
  `LPG_ASSERT_SAME(a_on_screen_coords, out_tvalid && !out_tuser, !out_tdata[X_MSB] && !out_tdata[Y_MSB])

  // a stalled pixel beat holds
  `LPG_ASSERT_NEXT(a_out_hold, out_tvalid && !out_tready, out_tvalid && $stable(out_beat))

endmodule

bind line_pixel_generator lpg_checker u_lpg_checker (.*);

// ----- sim/tb_line_pixel_generator.sv -----
`timescale 1ns / 100ps

module tb_line_pixel_generator;
  import lpg_pkg::*;

  localparam int IDLE_LIMIT       = 500;
  localparam int DRAIN_CYCLES     = 6;
  localparam int PHASES           = 7;
  localparam int PIXELS_PER_PHASE = 250;
  localparam int C_MIN            = -(1 << (COORD_BITS - 1));
  localparam int C_MAX            = (1 << (COORD_BITS - 1)) - 1;

  typedef logic signed [COORD_BITS-1:0] coord_t;

  typedef struct packed {
    coord_t                x;
    coord_t                y;
    logic [ADDR_BITS-1:0]  addr;
    logic [COLOR_BITS-1:0] color;
    logic                  off;
    logic                  last;
  } pixel_beat_t;

  typedef enum bit {BY_MODEL, BY_HAND} row_check_e;

  typedef struct packed {
    logic                  op;
    coord_t                sx;
    coord_t                sy;
    coord_t                ex;
    coord_t                ey;
    logic [COLOR_BITS-1:0] color;
    row_check_e            check;
    pixel_beat_t           pix;
  } dir_row_t;

  logic                     clk;
  logic                     rst_n = 1'b0;
  logic                     in_tvalid = 1'b0;
  logic                     in_tready;
  logic [IN_DATA_BITS-1:0]  in_tdata = '0;
  logic                     in_tuser = 1'b0;
  logic                     out_tvalid;
  logic                     out_tready = 1'b0;
  logic [OUT_DATA_BITS-1:0] out_tdata;
  logic                     out_tuser;
  logic                     out_tlast;
  logic                     cfg_we = 1'b0;
  logic [CFG_IDX_BITS-1:0]  cfg_index = '0;
  logic [REG_BITS-1:0]      cfg_data = '0;

  // rasterizer state as the testbench sees it
  logic [REG_BITS-1:0]      frame_w = FRAME_WIDTH_RESET;
  logic [REG_BITS-1:0]      frame_h = FRAME_HEIGHT_RESET;
  coord_t                   pos_x = '0;
  coord_t                   pos_y = '0;
  coord_t                   goal_x = '0;
  coord_t                   goal_y = '0;
  logic [SPAN_BITS-1:0]     run_x = '0;
  logic [SPAN_BITS-1:0]     run_y = '0;
  logic                     dec_x = 1'b0;
  logic                     dec_y = 1'b0;
  logic signed [ERR_BITS-1:0] err_acc = '0;
  logic [COLOR_BITS-1:0]    ink = '0;
  logic                     drawing = 1'b0;

  pixel_beat_t pending_pixels [$];
  int          pixels_due = 0;
  int          fail_cnt = 0;
  int          beats_sent = 0;
  int          pixels_seen = 0;
  int          off_seen = 0;
  int          lines_done = 0;
  int          idle_cycles = 0;
  int          hold_left = 0;
  logic        calm = 1'b0;

  // directed beats: extremes, both operations, degenerate, idle step, restart
  dir_row_t dir_rows [23] = '{
    '{OP_START, 639, 479, 639, 479, 24'hFFFFFF, BY_HAND,
      '{639, 479, 921597, 24'hFFFFFF, 1'b0, 1'b1}},
    '{OP_STEP, 0, 0, 0, 0, 24'h0, BY_MODEL, '0},
    '{OP_START, 0, 0, 3, 1, 24'h000000, BY_HAND,
      '{3, 1, 1929, 24'h000000, 1'b0, 1'b0}},
    '{OP_STEP, 0, 0, 0, 0, 24'h0, BY_MODEL, '0},
    '{OP_STEP, 0, 0, 0, 0, 24'h0, BY_MODEL, '0},
    '{OP_STEP, 0, 0, 0, 0, 24'h0, BY_MODEL, '0},
    '{OP_STEP, 0, 0, 0, 0, 24'h0, BY_MODEL, '0},
    '{OP_START, -4096, -4096, 4095, 4095, 24'hAAAAAA, BY_HAND,
      '{4095, 4095, 0, 24'hAAAAAA, 1'b1, 1'b0}},
    '{OP_STEP, 0, 0, 0, 0, 24'h0, BY_MODEL, '0},
    '{OP_STEP, 0, 0, 0, 0, 24'h0, BY_MODEL, '0},
    '{OP_START, 4095, -1, -4096, 0, 24'h555555, BY_HAND,
      '{-4096, 0, 0, 24'h555555, 1'b1, 1'b0}},
    '{OP_STEP, 0, 0, 0, 0, 24'h0, BY_MODEL, '0},
    '{OP_START, -1, -1, 0, 0, 24'h123456, BY_HAND,
      '{0, 0, 0, 24'h123456, 1'b0, 1'b0}},
    '{OP_STEP, 0, 0, 0, 0, 24'h0, BY_MODEL, '0},
    '{OP_START, 5, 10, 5, 7, 24'hFF0000, BY_HAND,
      '{5, 7, 13455, 24'hFF0000, 1'b0, 1'b0}},
    '{OP_STEP, 0, 0, 0, 0, 24'h0, BY_MODEL, '0},
    '{OP_STEP, 0, 0, 0, 0, 24'h0, BY_MODEL, '0},
    '{OP_STEP, 0, 0, 0, 0, 24'h0, BY_MODEL, '0},
    '{OP_START, 0, 479, 0, 480, 24'h00FF00, BY_HAND,
      '{0, 480, 0, 24'h00FF00, 1'b1, 1'b0}},
    '{OP_STEP, 0, 0, 0, 0, 24'h0, BY_MODEL, '0},
    '{OP_START, 640, 0, 639, 0, 24'h0000FF, BY_HAND,
      '{639, 0, 1917, 24'h0000FF, 1'b0, 1'b0}},
    '{OP_STEP, 0, 0, 0, 0, 24'h0, BY_MODEL, '0},
    '{OP_STEP, 0, 0, 0, 0, 24'h0, BY_MODEL, '0}
  };

  line_pixel_generator i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser),
    .out_tlast (out_tlast),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic int frame_extent(logic [REG_BITS-1:0] reg_val);
    return (int'(reg_val) > FRAME_MAX) ? FRAME_MAX : int'(reg_val);
  endfunction

  function automatic coord_t clamp_coord(int v);
    if (v < C_MIN) return coord_t'(C_MIN);
    if (v > C_MAX) return coord_t'(C_MAX);
    return coord_t'(v);
  endfunction

  // coordinate a little around the visible range of one axis
  function automatic coord_t near_frame(int extent);
    return clamp_coord(int'($urandom_range(0, extent + 8)) - 4);
  endfunction

  // pixel beat for a position under the current frame size
  function automatic pixel_beat_t frame_pixel(coord_t x, coord_t y, logic last);
    pixel_beat_t p;
    int w;
    int h;
    w = frame_extent(frame_w);
    h = frame_extent(frame_h);
    p.x = x;
    p.y = y;
    p.color = ink;
    p.last = last;
    p.off = (x < 0) || (y < 0) || (int'(x) >= w) || (int'(y) >= h);
    p.addr = p.off ? '0 : ADDR_BITS'(3 * (int'(y) * w + int'(x)));
    return p;
  endfunction

  // bresenham step: latch on start and emit the end point, else emit current position and advance
  function automatic void next_pixel(input logic op, input coord_t sx, input coord_t sy,
                                     input coord_t ex, input coord_t ey,
                                     input logic [COLOR_BITS-1:0] color,
                                     output bit got, output pixel_beat_t pix);
    int dx;
    int dy;
    int twice;
    coord_t px;
    coord_t py;
    got = 1'b1;
    pix = '0;
    if (op == OP_START) begin
      dx = int'(ex) - int'(sx);
      dy = int'(ey) - int'(sy);
      pos_x = sx;
      pos_y = sy;
      goal_x = ex;
      goal_y = ey;
      run_x = SPAN_BITS'((dx < 0) ? -dx : dx);
      run_y = SPAN_BITS'((dy < 0) ? -dy : dy);
      dec_x = !(sx < ex);
      dec_y = !(sy < ey);
      err_acc = ERR_BITS'(int'(run_x) - int'(run_y));
      ink = color;
      drawing = (sx != ex) || (sy != ey);
      pix = frame_pixel(ex, ey, !drawing);
    end else if (!drawing) begin
      got = 1'b0;
    end else begin
      px = pos_x;
      py = pos_y;
      twice = 2 * int'(err_acc);
      if (twice > -int'(run_y)) begin
        err_acc = ERR_BITS'(int'(err_acc) - int'(run_y));
        pos_x = dec_x ? pos_x - 1'b1 : pos_x + 1'b1;
      end
      if (twice < int'(run_x)) begin
        err_acc = ERR_BITS'(int'(err_acc) + int'(run_x));
        pos_y = dec_y ? pos_y - 1'b1 : pos_y + 1'b1;
      end
      drawing = (pos_x != goal_x) || (pos_y != goal_y);
      pix = frame_pixel(px, py, !drawing);
    end
  endfunction

  // drive one input beat, wait for the handshake, then predict
  task automatic send_beat(input logic op, input coord_t sx, input coord_t sy,
                           input coord_t ex, input coord_t ey,
                           input logic [COLOR_BITS-1:0] color,
                           input row_check_e check, input pixel_beat_t hand_pix);
    bit got;
    pixel_beat_t pix;
    if (!calm && $urandom_range(0, 4) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= op;
    in_tdata  <= IN_DATA_BITS'({color, ey, ex, sy, sx});
    do @(posedge clk); while (!in_tready);
    beats_sent++;
    next_pixel(op, sx, sy, ex, ey, color, got, pix);
    if (check == BY_HAND) begin
      pending_pixels.push_back(hand_pix);
      pixels_due++;
    end else if (got) begin
      pending_pixels.push_back(pix);
      pixels_due++;
    end
  endtask

  // step beat with noise in the unused fields
  task automatic step_once();
    send_beat(OP_STEP, coord_t'($urandom), coord_t'($urandom), coord_t'($urandom),
              coord_t'($urandom), COLOR_BITS'($urandom), BY_MODEL, '0);
  endtask

  function automatic void check_field(string what, int want, int got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, what, want, got);
      fail_cnt++;
    end
  endfunction

  // result side backpressure
  always @(posedge clk) begin
    if (hold_left > 0) begin
      out_tready <= 1'b0;
      hold_left  <= hold_left - 1;
    end else if (!calm && $urandom_range(0, 5) == 0) begin
      out_tready <= 1'b0;
      hold_left  <= $urandom_range(0, 2);
    end else begin
      out_tready <= 1'b1;
    end
  end

  // compare every pixel beat against the oldest prediction
  always @(posedge clk) begin : pixel_check
    pixel_beat_t want;
    if (rst_n && out_tvalid && out_tready) begin
      pixels_seen++;
      if (out_tuser) off_seen++;
      if (out_tlast) lines_done++;
      if (pending_pixels.size() == 0) begin
        $display("%0t: unexpected pixel beat, expected none, got x=%0d y=%0d", $time,
                 int'(coord_t'(out_tdata[0 +: COORD_BITS])),
                 int'(coord_t'(out_tdata[COORD_BITS +: COORD_BITS])));
        fail_cnt++;
      end else begin
        want = pending_pixels.pop_front();
        check_field("pixel_x", int'(want.x), int'(coord_t'(out_tdata[0 +: COORD_BITS])));
        check_field("pixel_y", int'(want.y),
                    int'(coord_t'(out_tdata[COORD_BITS +: COORD_BITS])));
        check_field("byte_address", int'(want.addr),
                    int'(out_tdata[2*COORD_BITS +: ADDR_BITS]));
        check_field("pixel_color", int'(want.color),
                    int'(out_tdata[2*COORD_BITS+ADDR_BITS +: COLOR_BITS]));
        check_field("off_screen", int'(want.off), int'(out_tuser));
        check_field("last_pixel", int'(want.last), int'(out_tlast));
      end
    end
  end

  // watchdog on cycles without any handshake
  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("%0t: no beat moved for %0d cycles, %0d pixels outstanding", $time,
               idle_cycles, pending_pixels.size());
      $display("*** FAILED ***");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin : stimulus
    int w_eff;
    int h_eff;
    int pick;
    int reach;
    int base;
    coord_t sx;
    coord_t sy;
    coord_t ex;
    coord_t ey;
    logic [REG_BITS-1:0] new_w;
    logic [REG_BITS-1:0] new_h;

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed part under the reset frame size
    foreach (dir_rows[i]) begin
      send_beat(dir_rows[i].op, dir_rows[i].sx, dir_rows[i].sy, dir_rows[i].ex,
                dir_rows[i].ey, dir_rows[i].color, dir_rows[i].check, dir_rows[i].pix);
    end

    for (int ph = 0; ph <= PHASES; ph++) begin
      // drain, let a trailing idle step pass, then change the frame size
      if (ph > 0) begin
        in_tvalid <= 1'b0;
        while (pending_pixels.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (ph == PHASES) break;
        case (ph)
          1: begin new_w = 13'd1;    new_h = 13'd1;    end
          2: begin new_w = 13'd4096; new_h = 13'd4096; end
          3: begin new_w = 13'd8191; new_h = 13'd8191; end
          4: begin new_w = 13'd0;    new_h = 13'd0;    end
          5: begin new_w = 13'd4095; new_h = 13'd3;    end
          default: begin
            new_w = REG_BITS'($urandom_range(2, 700));
            new_h = REG_BITS'($urandom_range(2, 500));
            calm <= 1'b1;
          end
        endcase
        cfg_we    <= 1'b1;
        cfg_index <= REG_FRAME_WIDTH;
        cfg_data  <= new_w;
        @(posedge clk);
        cfg_index <= REG_FRAME_HEIGHT;
        cfg_data  <= new_h;
        @(posedge clk);
        cfg_we    <= 1'b0;
        frame_w = new_w;
        frame_h = new_h;
      end

      w_eff = frame_extent(frame_w);
      h_eff = frame_extent(frame_h);
      base = pixels_due;
      while (pixels_due - base < PIXELS_PER_PHASE) begin
        pick = $urandom_range(0, 99);
        if (pick < 70 || (pick >= 82 && pick < 92)) begin
          // line around the frame, mostly short
          sx = near_frame(w_eff);
          sy = near_frame(h_eff);
          if (pick < 5) begin
            ex = sx;
            ey = sy;
          end else begin
            reach = ($urandom_range(0, 19) == 0) ? 200 : 12;
            ex = clamp_coord(int'(sx) + int'($urandom_range(0, 2 * reach)) - reach);
            ey = clamp_coord(int'(sy) + int'($urandom_range(0, 2 * reach)) - reach);
          end
          send_beat(OP_START, sx, sy, ex, ey, COLOR_BITS'($urandom), BY_MODEL, '0);
          if (pick < 70) begin
            while (drawing) step_once();
          end else begin
            // cut short, the next start abandons it
            repeat ($urandom_range(0, 3)) step_once();
          end
        end else if (pick < 82) begin
          // anywhere in the coordinate range, only a few pixels
          send_beat(OP_START, coord_t'($urandom), coord_t'($urandom), coord_t'($urandom),
                    coord_t'($urandom), COLOR_BITS'($urandom), BY_MODEL, '0);
          repeat ($urandom_range(0, 6)) step_once();
        end else begin
          // stray steps, often with no line active
          repeat ($urandom_range(1, 3)) step_once();
        end
      end
    end

    $display("%0d input beats, %0d pixel beats checked, %0d off screen, %0d line ends",
             beats_sent, pixels_seen, off_seen, lines_done);
    $display("frame sizes covered: reset, 1x1, 4096x4096, oversized, 0x0, 4095x3, random");
    if (fail_cnt == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
+incdir+hdl
hdl/lpg_pkg.sv
hdl/lpg_front.sv
hdl/lpg_queue.sv
hdl/lpg_back.sv
hdl/line_pixel_generator.sv
hdl/lpg_checker.sv
sim/tb_line_pixel_generator.sv
